FILE: hw/rtl/fmts_pkg.sv
`timescale 1ns / 1ps

package fmts_pkg;

   // task codes, shared by requests, task register and result
   localparam logic [2:0] TASK_NORMAL   = 3'd0;
   localparam logic [2:0] TASK_STOP     = 3'd1;
   localparam logic [2:0] TASK_START    = 3'd2;
   localparam logic [2:0] TASK_HOME     = 3'd3;
   localparam logic [2:0] TASK_CONTACT  = 3'd4;
   localparam logic [2:0] TASK_GOTO     = 3'd5;
   localparam logic [2:0] TASK_SETFORCE = 3'd6;

   localparam logic [1:0] MODE_UNDEF = 2'd0;
   localparam logic [1:0] MODE_SPEED = 2'd1;
   localparam logic [1:0] MODE_POS   = 2'd2;
   localparam logic [1:0] MODE_FORCE = 2'd3;

   localparam logic [1:0] TACT_NONE    = 2'd0;
   localparam logic [1:0] TACT_STOP    = 2'd1;
   localparam logic [1:0] TACT_START   = 2'd2;
   localparam logic [1:0] TACT_REZERO  = 2'd3;

   localparam logic [2:0] MACT_QUERY = 3'd0;
   localparam logic [2:0] MACT_SPEED = 3'd1;
   localparam logic [2:0] MACT_POS   = 3'd2;
   localparam logic [2:0] MACT_FORCE = 3'd3;
   localparam logic [2:0] MACT_NONE  = 3'd4;

   // configuration register indexes
   localparam logic [2:0] REG_GOAL_POSITION = 3'd0;
   localparam logic [2:0] REG_GOAL_FORCE    = 3'd1;
   localparam logic [2:0] REG_CONTACT_THR   = 3'd2;
   localparam logic [2:0] REG_CURRENT_LIMIT = 3'd3;
   localparam logic [2:0] REG_FORCE_LIMIT   = 3'd4;
   localparam logic [2:0] REG_STALL_TICKS   = 3'd5;

   localparam logic [7:0]  WARMUP_FULL      = 8'd150;
   localparam logic [8:0]  SETTLE_NEEDED    = 9'd10;
   localparam logic [8:0]  SETTLE_MAX       = 9'd511;
   localparam logic signed [10:0] HOME_SPEED    = -11'sd300;
   localparam logic signed [10:0] CONTACT_SPEED = 11'sd800;
   localparam logic signed [16:0] FORCE_TOL     = 17'sd5;
   localparam int POS_TOL   = 3;
   localparam int POS_SCALE = 100;

   localparam logic [14:0] CONTACT_THR_RESET   = 15'd20;
   localparam logic [14:0] CURRENT_LIMIT_RESET = 15'd2000;
   localparam logic [14:0] FORCE_LIMIT_RESET   = 15'd1500;
   localparam logic [8:0]  STALL_TICKS_RESET   = 9'd400;

   typedef struct packed {
      logic [1:0]         task_action;
      logic [2:0]         mode_action;
      logic signed [10:0] speed_command;
      logic               safety_stop;
      logic [2:0]         task_now;
      logic [1:0]         mode_now;
   } result_type;

endpackage

FILE: hw/rtl/finger_motor_task_sequencer.sv
`timescale 1ns / 1ps

// A result is registered and appears on rsp_ in the cycle after its req_ transaction is accepted.
// One item per cycle while rsp_ is not stalled; the task step is a single combinational
// pass between the state registers and the result register.
// A held result stalls req_ until rsp_tready; a new item enters in the cycle it leaves.
// Reset (synchronous, active high): task home, mode speed, counters and held
// position zero, configuration registers at their documented defaults.
module finger_motor_task_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // requested_task[2:0], measured_force[18:3], motor_current[34:19],
   // position[66:35], zero fill
   input  logic [71:0] req_tdata,
   // op[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // task_action[1:0], mode_action[4:2], speed_command[15:5],
   // safety_stop[16], task_now[19:17], mode_now[21:20], zero fill
   output logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // configuration
   logic signed [15:0] goal_force_ff;
   logic [14:0]        contact_thr_ff;
   logic [14:0]        current_limit_ff;
   logic [14:0]        force_limit_ff;
   logic [8:0]         stall_ticks_ff;
   // position window for goto: trunc(pos/100) within goal +/- 2
   logic signed [25:0] pos_lo_ff, pos_hi_ff;
   logic signed [25:0] pos_lo_in, pos_hi_in;
   logic signed [25:0] goal_a, goal_b;

   // sequencer state
   logic [2:0]         task_ff, task_in;
   logic [1:0]         mode_ff, mode_in;
   logic [7:0]         warmup_ff, warmup_in;
   logic [8:0]         settle_ff, settle_in;
   logic signed [31:0] held_ff, held_in;
   logic signed [10:0] drive_ff, drive_in;

   fmts_pkg::result_type rsp_ff, rsp_in;
   logic                 rsp_valid_ff;

   logic               in_op;
   logic [2:0]         in_task;
   logic signed [15:0] in_force;
   logic signed [15:0] in_current;
   logic signed [31:0] in_pos;
   logic               accept;

   logic [16:0]        cur_mag;
   logic               trip_cond;
   logic [7:0]         warm_inc;
   logic [8:0]         settle_inc;
   logic               pos_close, force_close;
   logic signed [16:0] force_diff;

   assign in_op      = req_tuser;
   assign in_task    = req_tdata[2:0];
   assign in_force   = req_tdata[18:3];
   assign in_current = req_tdata[34:19];
   assign in_pos     = req_tdata[66:35];

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // window bounds from the goal being written
   always_comb begin
      goal_a = 26'(signed'(csr_wdata)) - 26'sd2;
      goal_b = 26'(signed'(csr_wdata)) + 26'sd2;
      pos_lo_in = goal_a * 26'(fmts_pkg::POS_SCALE);
      pos_hi_in = goal_b * 26'(fmts_pkg::POS_SCALE);
      if (goal_a <= 26'sd0) begin
         pos_lo_in = pos_lo_in - 26'(fmts_pkg::POS_SCALE - 1);
      end
      if (goal_b >= 26'sd0) begin
         pos_hi_in = pos_hi_in + 26'(fmts_pkg::POS_SCALE - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_force_ff    <= '0;
         contact_thr_ff   <= fmts_pkg::CONTACT_THR_RESET;
         current_limit_ff <= fmts_pkg::CURRENT_LIMIT_RESET;
         force_limit_ff   <= fmts_pkg::FORCE_LIMIT_RESET;
         stall_ticks_ff   <= fmts_pkg::STALL_TICKS_RESET;
         pos_lo_ff        <= -26'(3 * fmts_pkg::POS_SCALE - 1);
         pos_hi_ff        <= 26'(3 * fmts_pkg::POS_SCALE - 1);
      end else if (csr_valid) begin
         unique case (csr_index)
            fmts_pkg::REG_GOAL_POSITION: begin
               pos_lo_ff <= pos_lo_in;
               pos_hi_ff <= pos_hi_in;
            end
            fmts_pkg::REG_GOAL_FORCE:    goal_force_ff    <= csr_wdata;
            fmts_pkg::REG_CONTACT_THR:   contact_thr_ff   <= csr_wdata[14:0];
            fmts_pkg::REG_CURRENT_LIMIT: current_limit_ff <= csr_wdata[14:0];
            fmts_pkg::REG_FORCE_LIMIT:   force_limit_ff   <= csr_wdata[14:0];
            fmts_pkg::REG_STALL_TICKS:   stall_ticks_ff   <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cur_mag    = in_current[15] ? 17'(-18'(in_current)) : 17'(in_current);
      trip_cond  = (cur_mag > {2'b00, current_limit_ff}) ||
                   (in_force > signed'({1'b0, force_limit_ff}));
      warm_inc   = (warmup_ff < fmts_pkg::WARMUP_FULL) ? warmup_ff + 8'd1 : warmup_ff;
      settle_inc = (settle_ff != fmts_pkg::SETTLE_MAX) ? settle_ff + 9'd1 : settle_ff;
      pos_close  = (in_pos >= 32'(pos_lo_ff)) && (in_pos <= 32'(pos_hi_ff));
      force_diff = 17'(goal_force_ff) - 17'(in_force);
      force_close = (force_diff > -fmts_pkg::FORCE_TOL) &&
                    (force_diff < fmts_pkg::FORCE_TOL);
   end

   // one pass of the task step for the item at the port
   always_comb begin
      task_in   = task_ff;
      mode_in   = mode_ff;
      warmup_in = warmup_ff;
      settle_in = settle_ff;
      held_in   = held_ff;
      drive_in  = drive_ff;
      rsp_in    = '{task_action: fmts_pkg::TACT_NONE, mode_action: fmts_pkg::MACT_NONE,
                    speed_command: '0, safety_stop: 1'b0,
                    task_now: '0, mode_now: '0};

      if (in_op) begin
         if (in_task <= fmts_pkg::TASK_SETFORCE) begin
            task_in = in_task;
         end
      end else begin
         warmup_in = warm_inc;
         unique case (task_ff)
            fmts_pkg::TASK_STOP: begin
               rsp_in.task_action = fmts_pkg::TACT_STOP;
               task_in = fmts_pkg::TASK_NORMAL;
               mode_in = fmts_pkg::MODE_UNDEF;
            end
            fmts_pkg::TASK_START: begin
               rsp_in.task_action = fmts_pkg::TACT_START;
               task_in = fmts_pkg::TASK_NORMAL;
               mode_in = fmts_pkg::MODE_UNDEF;
            end
            fmts_pkg::TASK_HOME: begin
               drive_in = fmts_pkg::HOME_SPEED;
               if (in_pos == held_ff) begin
                  settle_in = settle_inc;
               end else begin
                  settle_in = '0;
                  held_in   = in_pos;
               end
               if (warm_inc >= fmts_pkg::WARMUP_FULL && trip_cond) begin
                  warmup_in = '0;
               end
               // stall or safety trip ends homing
               if ((warm_inc >= fmts_pkg::WARMUP_FULL && trip_cond) ||
                   settle_in >= stall_ticks_ff) begin
                  settle_in = '0;
                  rsp_in.task_action = fmts_pkg::TACT_REZERO;
                  task_in = fmts_pkg::TASK_NORMAL;
                  mode_in = fmts_pkg::MODE_UNDEF;
               end
            end
            fmts_pkg::TASK_CONTACT: begin
               if (in_force > signed'({1'b0, contact_thr_ff})) begin
                  drive_in = '0;
                  task_in  = fmts_pkg::TASK_STOP;
               end else begin
                  drive_in = fmts_pkg::CONTACT_SPEED;
               end
            end
            fmts_pkg::TASK_GOTO, fmts_pkg::TASK_SETFORCE: begin
               if ((task_ff == fmts_pkg::TASK_GOTO) ? pos_close : force_close) begin
                  settle_in = settle_inc;
                  if (settle_inc >= fmts_pkg::SETTLE_NEEDED) begin
                     settle_in = '0;
                     task_in   = fmts_pkg::TASK_NORMAL;
                     mode_in   = (task_ff == fmts_pkg::TASK_GOTO) ?
                                 fmts_pkg::MODE_POS : fmts_pkg::MODE_FORCE;
                  end
               end else begin
                  settle_in = '0;
               end
            end
            default: ;
         endcase

         case (mode_in)
            fmts_pkg::MODE_SPEED: begin
               rsp_in.mode_action   = fmts_pkg::MACT_SPEED;
               rsp_in.speed_command = drive_in;
            end
            fmts_pkg::MODE_POS:   rsp_in.mode_action = fmts_pkg::MACT_POS;
            fmts_pkg::MODE_FORCE: rsp_in.mode_action = fmts_pkg::MACT_FORCE;
            default:              rsp_in.mode_action = fmts_pkg::MACT_QUERY;
         endcase

         // end-of-tick safety check, skipped while homing carries on
         if (task_in != fmts_pkg::TASK_HOME &&
             warmup_in >= fmts_pkg::WARMUP_FULL && trip_cond) begin
            warmup_in = '0;
            rsp_in.safety_stop = 1'b1;
            task_in = fmts_pkg::TASK_STOP;
         end
      end
      rsp_in.task_now = task_in;
      rsp_in.mode_now = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         task_ff      <= fmts_pkg::TASK_HOME;
         mode_ff      <= fmts_pkg::MODE_SPEED;
         warmup_ff    <= '0;
         settle_ff    <= '0;
         held_ff      <= '0;
         drive_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            task_ff   <= task_in;
            mode_ff   <= mode_in;
            warmup_ff <= warmup_in;
            settle_ff <= settle_in;
            held_ff   <= held_in;
            drive_ff  <= drive_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.mode_now, rsp_ff.task_now, rsp_ff.safety_stop,
                        rsp_ff.speed_command, rsp_ff.mode_action, rsp_ff.task_action};

   a_warmup_bounded: assert property (@(posedge clock) disable iff (reset)
      warmup_ff <= fmts_pkg::WARMUP_FULL)
      else $error("warm-up counter beyond full");

   a_stop_sets_task: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.safety_stop |-> rsp_ff.task_now == fmts_pkg::TASK_STOP)
      else $error("safety stop without stop task");

   a_request_quiet: assert property (@(posedge clock) disable iff (reset)
      accept && in_op |=> rsp_ff.mode_action == fmts_pkg::MACT_NONE &&
                          rsp_ff.task_action == fmts_pkg::TACT_NONE)
      else $error("request transaction produced an action");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff && rsp_ff.task_now == task_ff && rsp_ff.mode_now == mode_ff)
      else $error("result does not match state");

   a_task_legal: assert property (@(posedge clock) disable iff (reset)
      task_ff <= fmts_pkg::TASK_SETFORCE)
      else $error("task register holds unused code");

endmodule
